/* rtl/core/pfuic_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pfuic_pkg;

    // fixed field widths
    localparam int FILE_W = 8;
    localparam int NODE_W = 17;
    localparam int KEY_W  = 17;
    localparam int VAL_W  = 16;
    localparam int TAG_W  = FILE_W + 1;

    // command codes on the request channel
    localparam logic [1:0] CMD_VISIT = 2'd0;
    localparam logic [1:0] CMD_COUNT = 2'd1;
    localparam logic [1:0] CMD_HIST  = 2'd2;

    typedef enum logic [1:0] {
        OP_VISIT,
        OP_COUNT,
        OP_HIST,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_ORDER = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_IDRD,
        S_BDEC_RD,
        S_BDEC_WR,
        S_BINC_RD,
        S_BINC_WR,
        S_HRD,
        S_OUT
    } state_t;

    // classified request passed from front to back
    typedef struct packed {
        op_t                 op;
        logic                bad;
        logic [KEY_W-1:0]    key;
        logic [FILE_W-1:0]   file_number;
    } front_item_t;

endpackage

`default_nettype wire

/* rtl/core/pfuic_item_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pfuic_item_if #(
    parameter int BIN_W = 9
);
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [16:0] node;
    logic [7:0]         file_number;
    logic [BIN_W-1:0]   bin;

    modport source (output valid, cmd, node, file_number, bin, input ready);
    modport sink (input valid, cmd, node, file_number, bin, output ready);
endinterface

`default_nettype wire

/* rtl/core/pfuic_result_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pfuic_result_if #(
    parameter int CNT_W = 9
);
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [CNT_W-1:0] id_count;
    logic             id_unique;
    logic [15:0]      bin_value;
    logic [15:0]      unique_total;

    modport source (output valid, status, id_count, id_unique, bin_value, unique_total,
                    input ready);
    modport sink (input valid, status, id_count, id_unique, bin_value, unique_total,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/pfuic_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pfuic_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/pfuic_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module pfuic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

`default_nettype wire

/* rtl/core/pfuic_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module pfuic_front
    import pfuic_pkg::*;
#(
    parameter int ID_SPACE   = 65536,
    parameter int FILE_LIMIT = 256
) (
    pfuic_item_if.sink         req,
    input  wire logic [15:0]   num_ids,
    input  wire logic          blocked,
    output logic               push_valid,
    output front_item_t        push_data
);
    logic [NODE_W-1:0] raw;
    logic [KEY_W-1:0]  mag;
    logic              id_bad;
    logic              bin_bad;

    // accept whenever the queue has room and the store is not being cleared
    assign req.ready  = !blocked;
    assign push_valid = req.valid && !blocked;

    // id magnitude and range checks
    always_comb
    begin
        raw     = req.node;
        mag     = raw[NODE_W-1] ? (~raw + KEY_W'(1)) : raw;
        id_bad  = (mag == '0) || (mag > {1'b0, num_ids}) || (32'(mag) >= ID_SPACE);
        bin_bad = 32'(req.bin) > FILE_LIMIT;
    end

    // classify the transaction
    always_comb
    begin
        push_data.file_number = req.file_number;
        push_data.key         = mag;
        push_data.bad         = 1'b0;
        case (req.cmd)
            CMD_VISIT:
            begin
                push_data.op  = OP_VISIT;
                push_data.bad = id_bad;
            end
            CMD_COUNT:
            begin
                push_data.op  = OP_COUNT;
                push_data.bad = id_bad;
            end
            CMD_HIST:
            begin
                push_data.op  = OP_HIST;
                push_data.bad = bin_bad;
                push_data.key = KEY_W'(req.bin);
            end
            default:
            begin
                push_data.op  = OP_NOP;
            end
        endcase
    end
endmodule

`default_nettype wire

/* rtl/core/pfuic_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module pfuic_queue
    import pfuic_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push_valid,
    input  front_item_t       push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              pop_valid,
    output front_item_t       pop_data
);
    front_item_t slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        do_push;
    logic        do_pop;

    assign full      = (fill_reg == 2'd2);
    assign pop_valid = (fill_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

`default_nettype wire

/* rtl/core/pfuic_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module pfuic_back
    import pfuic_pkg::*;
#(
    parameter int ID_SPACE   = 65536,
    parameter int FILE_LIMIT = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] num_ids,
    input  wire logic        q_valid,
    input  front_item_t      q_data,
    output logic             q_pop,
    output logic             clearing,
    pfuic_result_if.source   rsp
);
    localparam int AW    = $clog2(ID_SPACE);
    localparam int CW    = $clog2(FILE_LIMIT + 1);
    localparam int BD    = FILE_LIMIT + 1;
    localparam int EW    = TAG_W + 1 + CW;
    localparam int SWEEP = (ID_SPACE > BD) ? ID_SPACE : BD;
    localparam int CLW   = $clog2(SWEEP);

    state_t            st_reg, st_next;
    logic [CLW-1:0]    clr_reg, clr_next;
    logic [FILE_W-1:0] cur_file_reg, cur_file_next;
    logic [VAL_W-1:0]  rep_tot_reg, rep_tot_next;
    logic [VAL_W-1:0]  seen_tot_reg, seen_tot_next;
    logic              out_valid_reg, out_valid_next;

    front_item_t       item_reg, item_next;
    logic [CW-1:0]     old_reg, old_next;
    logic              inc_reg, inc_next;
    status_t           w_status_reg, w_status_next;
    logic [CW-1:0]     w_cnt_reg, w_cnt_next;
    logic              w_uniq_reg, w_uniq_next;
    logic [VAL_W-1:0]  w_bval_reg, w_bval_next;
    status_t           out_status_reg, out_status_next;
    logic [CW-1:0]     out_cnt_reg, out_cnt_next;
    logic              out_uniq_reg, out_uniq_next;
    logic [VAL_W-1:0]  out_bval_reg, out_bval_next;
    logic [VAL_W-1:0]  out_total_reg, out_total_next;

    logic              id_we;
    logic [AW-1:0]     id_addr;
    logic [EW-1:0]     id_wdata;
    logic [EW-1:0]     id_rdata;
    logic              bin_we;
    logic [CW-1:0]     bin_addr;
    logic [VAL_W-1:0]  bin_wdata;
    logic [VAL_W-1:0]  bin_rdata;

    logic              fn_ok;
    logic [TAG_W-1:0]  tag;
    logic [TAG_W-1:0]  ent_last;
    logic              ent_mark;
    logic [CW-1:0]     ent_cnt;
    logic              same_file;
    logic              newly_marked;
    logic              grow;
    logic              need_dec;
    logic              out_free;
    logic [VAL_W-1:0]  uniq_now;
    logic [VAL_W-1:0]  bin_zero;

    // per-id entry: last file tag, repeat mark, count
    pfuic_ram #(.WIDTH(EW), .DEPTH(ID_SPACE)) u_id_ram (
        .clk   (clk),
        .we    (id_we),
        .addr  (id_addr),
        .wdata (id_wdata),
        .rdata (id_rdata)
    );

    // histogram of counts of unique ids
    pfuic_ram #(.WIDTH(VAL_W), .DEPTH(BD)) u_bin_ram (
        .clk   (clk),
        .we    (bin_we),
        .addr  (bin_addr),
        .wdata (bin_wdata),
        .rdata (bin_rdata)
    );

    // decode of the fetched entry and file order
    always_comb
    begin
        tag          = {1'b0, item_reg.file_number} + TAG_W'(1);
        ent_last     = id_rdata[EW-1 -: TAG_W];
        ent_mark     = id_rdata[CW];
        ent_cnt      = id_rdata[CW-1:0];
        same_file    = (ent_last == tag);
        newly_marked = same_file && !ent_mark;
        grow         = !same_file && !ent_mark && (32'(ent_cnt) < FILE_LIMIT);
        need_dec     = (newly_marked || grow) && (ent_cnt != '0);
        fn_ok        = ((q_data.file_number == cur_file_reg)
                        || ({1'b0, q_data.file_number} == {1'b0, cur_file_reg} + TAG_W'(1)))
                       && (32'(q_data.file_number) < FILE_LIMIT);
        uniq_now     = (num_ids > rep_tot_reg) ? (num_ids - rep_tot_reg) : '0;
        bin_zero     = (uniq_now > seen_tot_reg) ? (uniq_now - seen_tot_reg) : '0;
        out_free     = !out_valid_reg || rsp.ready;
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_CLEAR:
            begin
                if (clr_reg == CLW'(SWEEP - 1))
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_data.op)
                        OP_VISIT: st_next = (!fn_ok || q_data.bad) ? S_OUT : S_IDRD;
                        OP_COUNT: st_next = q_data.bad ? S_OUT : S_IDRD;
                        OP_HIST:
                            st_next = (q_data.bad || q_data.key == '0) ? S_OUT : S_HRD;
                        default: st_next = S_OUT;
                    endcase
                end
            end
            S_IDRD:
            begin
                if (item_reg.op != OP_VISIT)
                begin
                    st_next = S_OUT;
                end
                else if (need_dec)
                begin
                    st_next = S_BDEC_RD;
                end
                else if (grow)
                begin
                    st_next = S_BINC_RD;
                end
                else
                begin
                    st_next = S_OUT;
                end
            end
            S_BDEC_RD: st_next = S_BDEC_WR;
            S_BDEC_WR: st_next = inc_reg ? S_BINC_RD : S_OUT;
            S_BINC_RD: st_next = S_BINC_WR;
            S_BINC_WR: st_next = S_OUT;
            S_HRD:     st_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    st_next = S_IDLE;
                end
            end
            default:   st_next = S_IDLE;
        endcase
    end

    // datapath, memory ports and result register
    always_comb
    begin
        clr_next        = clr_reg;
        cur_file_next   = cur_file_reg;
        rep_tot_next    = rep_tot_reg;
        seen_tot_next   = seen_tot_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        item_next       = item_reg;
        old_next        = old_reg;
        inc_next        = inc_reg;
        w_status_next   = w_status_reg;
        w_cnt_next      = w_cnt_reg;
        w_uniq_next     = w_uniq_reg;
        w_bval_next     = w_bval_reg;
        out_status_next = out_status_reg;
        out_cnt_next    = out_cnt_reg;
        out_uniq_next   = out_uniq_reg;
        out_bval_next   = out_bval_reg;
        out_total_next  = out_total_reg;
        q_pop           = 1'b0;
        id_we           = 1'b0;
        id_addr         = AW'(item_reg.key);
        id_wdata        = '0;
        bin_we          = 1'b0;
        bin_addr        = old_reg;
        bin_wdata       = '0;

        case (st_reg)
            // zero both stores one entry a cycle
            S_CLEAR:
            begin
                clr_next = clr_reg + CLW'(1);
                id_we    = (32'(clr_reg) < ID_SPACE);
                id_addr  = AW'(clr_reg);
                bin_we   = (32'(clr_reg) < BD);
                bin_addr = CW'(clr_reg);
            end
            // take one transaction and start its reads
            S_IDLE:
            begin
                id_addr  = AW'(q_data.key);
                bin_addr = CW'(q_data.key);
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    item_next     = q_data;
                    w_status_next = STAT_OK;
                    w_cnt_next    = '0;
                    w_uniq_next   = 1'b0;
                    w_bval_next   = '0;
                    inc_next      = 1'b0;
                    case (q_data.op)
                        OP_VISIT:
                        begin
                            if (!fn_ok)
                            begin
                                w_status_next = STAT_ORDER;
                            end
                            else if (q_data.bad)
                            begin
                                w_status_next = STAT_RANGE;
                            end
                        end
                        OP_COUNT:
                        begin
                            if (q_data.bad)
                            begin
                                w_status_next = STAT_RANGE;
                            end
                        end
                        OP_HIST:
                        begin
                            if (q_data.bad)
                            begin
                                w_status_next = STAT_RANGE;
                            end
                            else if (q_data.key == '0)
                            begin
                                w_bval_next = bin_zero;
                            end
                        end
                        default:
                        begin
                            w_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            // entry arrived: update it
            S_IDRD:
            begin
                old_next    = ent_cnt;
                w_cnt_next  = ent_cnt;
                w_uniq_next = !ent_mark;
                if (item_reg.op == OP_VISIT)
                begin
                    cur_file_next = item_reg.file_number;
                    inc_next      = grow;
                    if (newly_marked)
                    begin
                        id_we        = 1'b1;
                        id_wdata     = {ent_last, 1'b1, CW'(0)};
                        rep_tot_next = rep_tot_reg + VAL_W'(1);
                        w_cnt_next   = '0;
                        w_uniq_next  = 1'b0;
                        if (ent_cnt != '0)
                        begin
                            seen_tot_next = seen_tot_reg - VAL_W'(1);
                        end
                    end
                    else if (!same_file)
                    begin
                        id_we    = 1'b1;
                        id_wdata = {tag, ent_mark, ent_cnt};
                        if (grow)
                        begin
                            id_wdata   = {tag, ent_mark, ent_cnt + CW'(1)};
                            w_cnt_next = ent_cnt + CW'(1);
                            if (ent_cnt == '0)
                            begin
                                seen_tot_next = seen_tot_reg + VAL_W'(1);
                            end
                        end
                    end
                end
            end
            S_BDEC_RD:
            begin
                bin_addr = old_reg;
            end
            S_BDEC_WR:
            begin
                bin_we    = 1'b1;
                bin_addr  = old_reg;
                bin_wdata = bin_rdata - VAL_W'(1);
            end
            S_BINC_RD:
            begin
                bin_addr = old_reg + CW'(1);
            end
            S_BINC_WR:
            begin
                bin_we    = 1'b1;
                bin_addr  = old_reg + CW'(1);
                bin_wdata = bin_rdata + VAL_W'(1);
            end
            S_HRD:
            begin
                w_bval_next = bin_rdata;
            end
            // hand the result to the output register
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = w_status_reg;
                    out_cnt_next    = w_cnt_reg;
                    out_uniq_next   = w_uniq_reg;
                    out_bval_next   = w_bval_reg;
                    out_total_next  = uniq_now;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_CLEAR;
            clr_reg       <= '0;
            cur_file_reg  <= '0;
            rep_tot_reg   <= '0;
            seen_tot_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            clr_reg       <= clr_next;
            cur_file_reg  <= cur_file_next;
            rep_tot_reg   <= rep_tot_next;
            seen_tot_reg  <= seen_tot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        old_reg        <= old_next;
        inc_reg        <= inc_next;
        w_status_reg   <= w_status_next;
        w_cnt_reg      <= w_cnt_next;
        w_uniq_reg     <= w_uniq_next;
        w_bval_reg     <= w_bval_next;
        out_status_reg <= out_status_next;
        out_cnt_reg    <= out_cnt_next;
        out_uniq_reg   <= out_uniq_next;
        out_bval_reg   <= out_bval_next;
        out_total_reg  <= out_total_next;
    end

    assign clearing         = (st_reg == S_CLEAR);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.id_count     = out_cnt_reg;
    assign rsp.id_unique    = out_uniq_reg;
    assign rsp.bin_value    = out_bval_reg;
    assign rsp.unique_total = out_total_reg;

    // no transaction leaves the queue during the clearing pass
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_CLEAR) |-> !q_pop)
        else $error("queue popped while clearing");

    // histogram writes only in clear or update steps
    a_bin_write: assert property (@(posedge clk) disable iff (!rst_n)
        bin_we |-> (st_reg == S_CLEAR || st_reg == S_BDEC_WR || st_reg == S_BINC_WR))
        else $error("unexpected histogram write");

    // the repeat total only grows
    a_rep_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_CLEAR) |=> (rep_tot_reg >= $past(rep_tot_reg)))
        else $error("repeat total dropped");
endmodule

`default_nettype wire

/* rtl/core/per_file_unique_id_counter_core.sv */
// channel  | dir | handshake       | payload
// req      | in  | valid / ready   | cmd, node, file_number, bin
// rsp      | out | valid / ready   | status, id_count, id_unique, bin_value, unique_total
// cfg      | in  | valid / ready   | data (num_ids)
//
// errors, no-ops and histogram bin zero go straight to the result step, a count or
// histogram read waits on one memory read, and a visit may add histogram decrement and
// increment steps, as the single-port id and histogram memories serialize the
// read-modify-write steps of one visit; after reset a clearing pass over max(ID_SPACE,
// FILE_LIMIT+1) entries zeroes both memories; req.ready stays low meanwhile, cfg writes
// are taken; a two-entry queue parts request intake from the update sequencer, and the
// output register lets the next transaction start while a result waits on rsp.ready
`timescale 1ns / 1ps
`default_nettype none

module per_file_unique_id_counter_core
    import pfuic_pkg::*;
#(
    parameter int ID_SPACE   = 65536,
    parameter int FILE_LIMIT = 256
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    pfuic_item_if.sink     req,
    pfuic_result_if.source rsp,
    pfuic_cfg_if.sink      cfg
);
    logic [15:0]  num_ids_reg;
    logic         q_full;
    logic         q_pop;
    logic         q_valid;
    logic         push_valid;
    logic         clearing;
    front_item_t  push_data;
    front_item_t  q_data;

    // configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_ids_reg <= '0;
        end
        else if (cfg.valid)
        begin
            num_ids_reg <= cfg.data;
        end
    end

    pfuic_front #(.ID_SPACE(ID_SPACE), .FILE_LIMIT(FILE_LIMIT)) u_front (
        .req        (req),
        .num_ids    (num_ids_reg),
        .blocked    (q_full || clearing),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    pfuic_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    pfuic_back #(.ID_SPACE(ID_SPACE), .FILE_LIMIT(FILE_LIMIT)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .num_ids  (num_ids_reg),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .clearing (clearing),
        .rsp      (rsp)
    );
endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
    import pfuic_pkg::*;

    localparam int IDS   = 65536;
    localparam int FLIM  = 256;
    localparam int LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pfuic_item_if   req ();
    pfuic_result_if rsp ();
    pfuic_cfg_if    cfg ();

    per_file_unique_id_counter_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    always #5 clk = ~clk;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  id_count;
        logic        id_unique;
        logic [15:0] bin_value;
        logic [15:0] unique_total;
    } tally_t;

    // predictor of the id tallies and histogram, plus the queue of expected answers
    class tally_board;
        logic [15:0] max_id;
        logic [8:0]  cnt [IDS];
        bit          dup [IDS];
        logic [8:0]  last_tag [IDS];
        logic [7:0]  cur_file;
        logic [15:0] hist [FLIM+1];
        logic [15:0] dup_total;
        logic [15:0] seen_total;
        tally_t      pending [$];
        int          errors;
        int          checked;

        function new();
            max_id = 0;
            cur_file = 0;
            dup_total = 0;
            seen_total = 0;
            errors = 0;
            checked = 0;
            foreach (cnt[i])
            begin
                cnt[i] = 0;
                dup[i] = 0;
                last_tag[i] = 0;
            end
            foreach (hist[i])
                hist[i] = 0;
        endfunction

        function int unsigned sub0(int unsigned a, int unsigned b);
            return a > b ? a - b : 0;
        endfunction

        function bit id_valid(int unsigned id);
            return id != 0 && id <= max_id && id < IDS;
        endfunction

        // work out the answer to one accepted request and queue it
        function void note_request(logic [1:0] cmd, logic signed [16:0] node,
                                   logic [7:0] fnum, logic [8:0] bin);
            tally_t      t;
            int unsigned id;
            int unsigned old;
            logic [8:0]  tag;
            id = node[16] ? (32'h20000 - {15'd0, node}) : {15'd0, node};
            t = '{default: '0};
            if (cmd == CMD_VISIT)
            begin
                if ((fnum != cur_file && {1'b0, fnum} != {1'b0, cur_file} + 9'd1))
                    t.status = STAT_ORDER;
                else if (!id_valid(id))
                    t.status = STAT_RANGE;
                else
                begin
                    tag = {1'b0, fnum} + 9'd1;
                    old = cnt[id];
                    cur_file = fnum;
                    if (last_tag[id] == tag)
                    begin
                        if (!dup[id])
                        begin
                            dup[id] = 1;
                            if (old > 0)
                            begin
                                hist[old] = hist[old] - 16'd1;
                                seen_total = seen_total - 16'd1;
                            end
                            cnt[id] = 0;
                            dup_total = dup_total + 16'd1;
                        end
                    end
                    else
                    begin
                        last_tag[id] = tag;
                        if (!dup[id] && old < FLIM)
                        begin
                            if (old == 0)
                                seen_total = seen_total + 16'd1;
                            else
                                hist[old] = hist[old] - 16'd1;
                            hist[old+1] = hist[old+1] + 16'd1;
                            cnt[id] = 9'(old + 1);
                        end
                    end
                    t.id_count = cnt[id];
                    t.id_unique = !dup[id];
                end
            end
            else if (cmd == CMD_COUNT)
            begin
                if (!id_valid(id))
                    t.status = STAT_RANGE;
                else
                begin
                    t.id_count = cnt[id];
                    t.id_unique = !dup[id];
                end
            end
            else if (cmd == CMD_HIST)
            begin
                if (bin > FLIM)
                    t.status = STAT_RANGE;
                else if (bin == 0)
                    t.bin_value = 16'(sub0(sub0(max_id, dup_total), seen_total));
                else
                    t.bin_value = hist[bin];
            end
            t.unique_total = 16'(sub0(max_id, dup_total));
            pending = {pending, t};
        endfunction

        // compare one accepted answer against the oldest expectation
        function void check_answer(tally_t got);
            tally_t exp_t;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected answer status=%0d", got.status);
                return;
            end
            exp_t = pending.pop_front();
            checked++;
            if (got != exp_t)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp st=%0d cnt=%0d u=%0d bin=%0d tot=%0d",
                        exp_t.status, exp_t.id_count, exp_t.id_unique, exp_t.bin_value,
                        exp_t.unique_total,
                        " got st=%0d cnt=%0d u=%0d bin=%0d tot=%0d",
                        got.status, got.id_count, got.id_unique,
                        got.bin_value, got.unique_total);
            end
        endfunction
    endclass

    tally_board board = new();
    int cycles = 0;
    int sent = 0;
    int visits = 0;
    logic [7:0] file_now = 0;
    bit stall_mode = 0;

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: sample at rising edge, vary ready at falling edge
    always @(posedge clk)
    begin
        tally_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.status = rsp.status;
            got.id_count = rsp.id_count;
            got.id_unique = rsp.id_unique;
            got.bin_value = rsp.bin_value;
            got.unique_total = rsp.unique_total;
            board.check_answer(got);
        end
    end

    initial
    begin
        int g;
        rsp.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            g = stall_mode ? gap_len() : 0;
            if (g > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            @(negedge clk);
        end
    end

    task automatic wait_idle();
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_max_id(logic [15:0] v);
        cfg.valid <= 1'b1;
        cfg.data <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        board.max_id = v;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // one request transaction; valid stays high across back-to-back sends
    task automatic send(logic [1:0] cmd, logic signed [16:0] node, logic [7:0] fnum,
                        logic [8:0] bin);
        int g;
        g = stall_mode ? gap_len() : 0;
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.cmd <= cmd;
        req.node <= node;
        req.file_number <= fnum;
        req.bin <= bin;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        board.note_request(cmd, node, fnum, bin);
        sent++;
        if (cmd == CMD_VISIT)
            visits++;
        @(negedge clk);
    endtask

    task automatic pause_req();
        req.valid <= 1'b0;
        @(negedge clk);
    endtask

    // random id signed either way, mostly in range, some at the edges
    function logic signed [16:0] pick_node(int unsigned hi);
        int unsigned id;
        int r;
        logic signed [16:0] v;
        r = $urandom_range(0, 19);
        if (r == 0)
            id = 0;
        else if (r == 1)
            id = $urandom_range(0, 65535);
        else if (r == 2)
            id = 65536;
        else
            id = $urandom_range(1, hi == 0 ? 1 : hi);
        v = 17'(id);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic random_phase(int n, int unsigned span);
        int r;
        int unsigned bn;
        logic [7:0] f;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                // mostly in order; occasionally next file or a bad one
                f = file_now;
                if ($urandom_range(0, 9) == 0 && file_now != 8'd255)
                    f = file_now + 8'd1;
                else if ($urandom_range(0, 29) == 0)
                    f = 8'($urandom_range(0, 255));
                send(CMD_VISIT, pick_node(span), f, 9'($urandom_range(0, 511)));
                if (board.cur_file != file_now)
                    file_now = board.cur_file;
            end
            else if (r < 82)
                send(CMD_COUNT, pick_node(span), 8'($urandom_range(0, 255)),
                     9'($urandom_range(0, 511)));
            else if (r < 97)
            begin
                bn = $urandom_range(0, 9) == 0 ? $urandom_range(0, 511) : $urandom_range(0, 6);
                send(CMD_HIST, 17'($urandom_range(0, 17'h1ffff)), 8'($urandom_range(0, 255)),
                     9'(bn));
            end
            else
                send(OP_NOP, 17'($urandom_range(0, 17'h1ffff)), 8'($urandom_range(0, 255)),
                     9'($urandom_range(0, 511)));
        end
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.cmd = CMD_VISIT;
        req.node = '0;
        req.file_number = '0;
        req.bin = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every command, error cases
        write_max_id(16'd65535);
        send(CMD_VISIT, 17'sd1, 8'd0, 9'd0);
        send(CMD_VISIT, -17'sd1, 8'd0, 9'd0);
        send(CMD_VISIT, 17'sd65535, 8'd0, 9'd0);
        send(CMD_VISIT, -17'sd65535, 8'd1, 9'd0);
        send(CMD_VISIT, 17'sd0, 8'd1, 9'd0);
        send(CMD_VISIT, -17'sd65536, 8'd1, 9'd0);
        send(CMD_VISIT, 17'sd7, 8'd5, 9'd0);
        send(CMD_VISIT, 17'sd7, 8'd0, 9'd0);
        send(CMD_VISIT, 17'sd7, 8'd2, 9'd0);
        send(CMD_COUNT, 17'sd1, 8'd0, 9'd0);
        send(CMD_COUNT, -17'sd65535, 8'd0, 9'd0);
        send(CMD_COUNT, 17'sd0, 8'd0, 9'd0);
        send(CMD_COUNT, -17'sd65536, 8'd0, 9'd0);
        send(CMD_HIST, 17'sd0, 8'd0, 9'd0);
        send(CMD_HIST, 17'sd0, 8'd0, 9'd1);
        send(CMD_HIST, 17'sd0, 8'd0, 9'd2);
        send(CMD_HIST, 17'sd0, 8'd0, 9'd256);
        send(CMD_HIST, 17'sd0, 8'd0, 9'd257);
        send(CMD_HIST, 17'sd0, 8'd0, 9'd511);
        send(OP_NOP, -17'sd1, 8'd255, 9'd511);
        send(CMD_VISIT, 17'sd1, 8'd255, 9'd0);
        pause_req();
        wait_idle();

        // long count: id 3 walks the files up to 255, one sighting each
        file_now = 1;
        for (int f = 1; f < 256; f++)
            send(CMD_VISIT, 17'sd3, f[7:0], 9'd0);
        send(CMD_HIST, 17'sd0, 8'd0, 9'd255);
        send(CMD_COUNT, 17'sd3, 8'd0, 9'd0);
        send(CMD_VISIT, 17'sd3, 8'd255, 9'd0);
        pause_req();
        wait_idle();

        // small id range, random with stalls on both sides
        stall_mode = 1;
        write_max_id(16'd40);
        file_now = board.cur_file;
        random_phase(150, 50);
        pause_req();
        wait_idle();

        write_max_id(16'd0);
        random_phase(40, 10);
        pause_req();
        wait_idle();

        write_max_id(16'd12);
        random_phase(120, 14);
        // hold the sender until all answers are back
        pause_req();
        wait_idle();
        stall_mode = 0;
        random_phase(60, 14);
        stall_mode = 1;
        pause_req();
        wait_idle();

        write_max_id(16'd65535);
        random_phase(100, 300);
        pause_req();
        wait_idle();

        $display("sent %0d requests (%0d visits), %0d answers checked, %0d files reached",
                 sent, visits, board.checked, board.cur_file);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d answers missing", board.errors, board.pending.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/core/pfuic_pkg.sv
rtl/core/pfuic_item_if.sv
rtl/core/pfuic_result_if.sv
rtl/core/pfuic_cfg_if.sv
rtl/core/pfuic_ram.sv
rtl/core/pfuic_front.sv
rtl/core/pfuic_queue.sv
rtl/core/pfuic_back.sv
rtl/core/per_file_unique_id_counter_core.sv
sim/tb.sv
